// ----- sv/afet_pkg.sv -----
// Shared types and constants of the adaptive flow expiry timer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package afet_pkg;

    localparam int TIME_BITS     = 48;
    localparam int COUNT_BITS    = 32;
    localparam int SUM_BITS      = COUNT_BITS + 1;
    localparam int MULT_BITS     = 8;
    localparam int PERIOD_BITS   = 32;
    localparam int PROTO_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int PROD_BITS     = TIME_BITS + MULT_BITS;
    localparam int CMP_BITS      = (SUM_BITS > PERIOD_BITS) ? SUM_BITS : PERIOD_BITS;

    localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
    localparam logic [PROTO_BITS-1:0] PROTO_TCP = PROTO_BITS'(6);

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = CFG_IDX_BITS'(4);

    localparam logic [MULT_BITS-1:0]   MULT_RESET  = MULT_BITS'(20);
    localparam logic [PERIOD_BITS-1:0] MIN_RESET   = PERIOD_BITS'(5000000);
    localparam logic [PERIOD_BITS-1:0] SHORT_RESET = PERIOD_BITS'(2000000);
    localparam logic [PERIOD_BITS-1:0] LIMIT_RESET = PERIOD_BITS'(6);

    typedef enum logic [1:0] {
        LIST_TCP,
        LIST_UDP,
        LIST_EXPIRED
    } t_list;

    typedef enum logic [1:0] {
        MODE_STD,
        MODE_SHORT,
        MODE_KEEP
    } t_mode;

    typedef enum logic [1:0] {
        CLOSE_OPEN,
        CLOSE_RESET,
        CLOSE_ICMP,
        CLOSE_CLOSED
    } t_close;

    typedef enum logic {
        PICK_FIXED,
        PICK_STREAM
    } t_pick;

    typedef struct packed {
        logic [SUM_BITS-1:0]  rem;
        logic [TIME_BITS-1:0] num;
        logic [SUM_BITS-1:0]  den;
    } t_div;

    typedef struct packed {
        t_pick                pick;
        logic [TIME_BITS-1:0] fixed_us;
        logic                 fixed_clip;
        logic [TIME_BITS-1:0] now_us;
        t_list                list;
    } t_side;

    typedef struct packed {
        logic [TIME_BITS-1:0] expiry_us;
        t_list                list;
        logic                 sat;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/afet_div_cell.sv -----
// One cell of the divider chain: a restoring step producing one quotient bit.
// Depends on afet_pkg for the divider and sideband structs.
`default_nettype none

module afet_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire afet_pkg::t_div  i_div,
    input  wire afet_pkg::t_side i_side,
    output logic                 o_valid,
    output afet_pkg::t_div       o_div,
    output afet_pkg::t_side      o_side
);
    import afet_pkg::*;

    logic [SUM_BITS:0] w_trial;
    logic [SUM_BITS:0] w_diff;
    logic              w_ge;
    t_div              n_div;
    logic              r_valid;
    t_div              r_div;
    t_side             r_side;

    always_comb begin
        w_trial   = {i_div.rem, i_div.num[TIME_BITS-1]};
        w_diff    = w_trial - {1'b0, i_div.den};
        w_ge      = (w_trial >= {1'b0, i_div.den});
        n_div.rem = w_ge ? w_diff[SUM_BITS-1:0] : w_trial[SUM_BITS-1:0];
        n_div.num = {i_div.num[TIME_BITS-2:0], w_ge};
        n_div.den = i_div.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ----- sv/afet_out_fifo.sv -----
// Two-entry result buffer between the pipeline and the output channel.
// Depends on afet_pkg for the result struct.
`default_nettype none

module afet_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire afet_pkg::t_result i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output afet_pkg::t_result      o_data,
    output logic                   o_full
);
    import afet_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ----- sv/adaptive_flow_expiry_timer_top.sv -----
// Top level of the adaptive flow expiry timer: front stage, divider chain,
// multiply stage and output buffer. Depends on afet_pkg, afet_div_cell, afet_out_fifo.
//
// Usage:
//   Input channel: i_in_valid with the flow fields, o_in_stall back. An item is
//   taken at a clock edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid with the result fields, i_out_stall back.
//   Config channel: i_cfg_valid / o_cfg_ready with register index and data;
//   o_cfg_ready is always high, writes are meant for idle periods only.
//   Path: an item taken passes one front register, one divider cell per quotient bit
//   (TIME_BITS cells), one multiply register and the output buffer before its result
//   shows on o_out_valid.
//   Throughput: one item per cycle while o_in_stall is low; the divider chain then
//   takes a new item every cycle and each cell works on a different item.
//   Stall: the two-entry output buffer keeps taking results while the receiver
//   stalls; once it is full the whole pipeline holds and o_in_stall rises.
//   Reset: synchronous, active low; clears all valid bits and the buffer and
//   loads the register reset values. No clearing pass is needed.
`default_nettype none

module adaptive_flow_expiry_timer_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_flow_start_us,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_flow_last_us,
    input  wire logic [afet_pkg::COUNT_BITS-1:0]    i_packets_inbound,
    input  wire logic [afet_pkg::COUNT_BITS-1:0]    i_packets_outbound,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_current_expiry_us,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_now_us,
    input  wire logic [afet_pkg::PROTO_BITS-1:0]    i_transport_proto,
    input  wire logic [1:0]                         i_close_state,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [afet_pkg::TIME_BITS-1:0]          o_new_expiry_us,
    output logic [1:0]                              o_target_list,
    output logic                                    o_saturated,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [afet_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [afet_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import afet_pkg::*;

    logic [1:0]             r_mode;
    logic [MULT_BITS-1:0]   r_mult;
    logic [PERIOD_BITS-1:0] r_min_period;
    logic [PERIOD_BITS-1:0] r_short_period;
    logic [PERIOD_BITS-1:0] r_short_limit;

    logic                   w_en;
    logic                   w_full;

    logic                   r_a_valid;
    logic [TIME_BITS-1:0]   r_a_start;
    logic [TIME_BITS-1:0]   r_a_last;
    logic [COUNT_BITS-1:0]  r_a_pin;
    logic [COUNT_BITS-1:0]  r_a_pout;
    logic [TIME_BITS-1:0]   r_a_expiry;
    logic [TIME_BITS-1:0]   r_a_now;
    logic [PROTO_BITS-1:0]  r_a_proto;
    logic [1:0]             r_a_close;

    logic [TIME_BITS-1:0]   w_length;
    logic [SUM_BITS-1:0]    w_count;
    logic [TIME_BITS:0]     w_min_sum;
    logic [TIME_BITS:0]     w_short_sum;
    logic [TIME_BITS-1:0]   w_min_end;
    logic [TIME_BITS-1:0]   w_short_end;
    logic                   w_in_min;
    logic                   w_below;
    t_side                  w_front_side;
    t_div                   w_front_div;

    logic                   w_vld  [TIME_BITS+1];
    t_div                   w_div  [TIME_BITS+1];
    t_side                  w_side [TIME_BITS+1];

    logic [TIME_BITS-1:0]   w_interval;
    logic [PROD_BITS-1:0]   w_prod;
    logic                   r_m_valid;
    logic [PROD_BITS-1:0]   r_m_prod;
    t_side                  r_m_side;

    logic                   w_st_clip;
    logic [TIME_BITS-1:0]   w_stream;
    logic [TIME_BITS:0]     w_end_sum;
    t_result                w_result;
    t_result                w_head;
    logic                   w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_STD;
            r_mult         <= MULT_RESET;
            r_min_period   <= MIN_RESET;
            r_short_period <= SHORT_RESET;
            r_short_limit  <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode         <= i_cfg_data[1:0];
                CFG_MULT:  r_mult         <= i_cfg_data[MULT_BITS-1:0];
                CFG_MIN:   r_min_period   <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_SHORT: r_short_period <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_LIMIT: r_short_limit  <= i_cfg_data[PERIOD_BITS-1:0];
                default:   ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_en        = !w_full;
    assign o_in_stall  = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_in_valid) begin
            r_a_start  <= i_flow_start_us;
            r_a_last   <= i_flow_last_us;
            r_a_pin    <= i_packets_inbound;
            r_a_pout   <= i_packets_outbound;
            r_a_expiry <= i_current_expiry_us;
            r_a_now    <= i_now_us;
            r_a_proto  <= i_transport_proto;
            r_a_close  <= i_close_state;
        end
    end

    always_comb begin
        w_length    = (r_a_last >= r_a_start) ? (r_a_last - r_a_start) : '0;
        w_count     = SUM_BITS'(r_a_pin) + SUM_BITS'(r_a_pout);
        w_min_sum   = {1'b0, r_a_start} + (TIME_BITS+1)'(r_min_period);
        w_short_sum = {1'b0, r_a_start} + (TIME_BITS+1)'(r_short_period);
        w_min_end   = w_min_sum[TIME_BITS] ? TIME_MAX : w_min_sum[TIME_BITS-1:0];
        w_short_end = w_short_sum[TIME_BITS] ? TIME_MAX : w_short_sum[TIME_BITS-1:0];
        w_in_min    = (r_a_now < w_min_end);
        w_below     = (CMP_BITS'(w_count) < CMP_BITS'(r_short_limit));

        w_front_side.pick       = PICK_FIXED;
        w_front_side.fixed_us   = r_a_expiry;
        w_front_side.fixed_clip = 1'b0;
        w_front_side.now_us     = r_a_now;
        w_front_side.list       = (r_a_proto == PROTO_TCP) ? LIST_TCP : LIST_UDP;

        unique case (r_mode)
            MODE_STD: begin
                if (r_a_expiry == '0) begin
                    w_front_side.fixed_us   = w_min_end;
                    w_front_side.fixed_clip = w_min_sum[TIME_BITS];
                end else if (!w_in_min) begin
                    w_front_side.pick = PICK_STREAM;
                end
            end
            MODE_SHORT: begin
                if (w_below) begin
                    w_front_side.fixed_us   = w_short_end;
                    w_front_side.fixed_clip = w_short_sum[TIME_BITS];
                end else if (!w_in_min) begin
                    w_front_side.pick = PICK_STREAM;
                end
            end
            default: ;
        endcase

        if (r_a_close != CLOSE_OPEN) begin
            w_front_side.pick       = PICK_FIXED;
            w_front_side.fixed_us   = r_a_now;
            w_front_side.fixed_clip = 1'b0;
            w_front_side.list       = LIST_EXPIRED;
        end

        w_front_div.rem = '0;
        w_front_div.num = w_length;
        w_front_div.den = w_count;
    end

    assign w_vld[0]  = r_a_valid;
    assign w_div[0]  = w_front_div;
    assign w_side[0] = w_front_side;

    for (genvar g = 0; g < TIME_BITS; g++) begin : g_cell
        afet_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_div   (w_div[g]),
            .i_side  (w_side[g]),
            .o_valid (w_vld[g+1]),
            .o_div   (w_div[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign w_interval = (w_div[TIME_BITS].den == '0) ? '0 : w_div[TIME_BITS].num;
    assign w_prod     = PROD_BITS'(w_interval) * PROD_BITS'(r_mult);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_vld[TIME_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_prod <= w_prod;
            r_m_side <= w_side[TIME_BITS];
        end
    end

    always_comb begin
        w_st_clip = |r_m_prod[PROD_BITS-1:TIME_BITS];
        w_stream  = w_st_clip ? TIME_MAX : r_m_prod[TIME_BITS-1:0];
        w_end_sum = {1'b0, w_stream} + {1'b0, r_m_side.now_us};
        w_result.list = r_m_side.list;
        unique case (r_m_side.pick)
            PICK_STREAM: begin
                w_result.expiry_us = w_end_sum[TIME_BITS] ? TIME_MAX
                                                          : w_end_sum[TIME_BITS-1:0];
                w_result.sat       = w_end_sum[TIME_BITS] || w_st_clip;
            end
            default: begin
                w_result.expiry_us = r_m_side.fixed_us;
                w_result.sat       = r_m_side.fixed_clip;
            end
        endcase
    end

    assign w_pop = o_out_valid && !i_out_stall;

    afet_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && r_m_valid),
        .i_data  (w_result),
        .i_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_data  (w_head),
        .o_full  (w_full)
    );

    assign o_new_expiry_us = w_head.expiry_us;
    assign o_target_list   = w_head.list;
    assign o_saturated     = w_head.sat;

endmodule

`default_nettype wire

// ----- sv/afet_checker.sv -----
// Port-level assertions for the adaptive flow expiry timer, bound to the top.
// Depends on afet_pkg and adaptive_flow_expiry_timer_top.
`default_nettype none

module afet_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [afet_pkg::TIME_BITS-1:0] o_new_expiry_us,
    input wire logic [1:0]                     o_target_list,
    input wire logic                           o_saturated
);
    import afet_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_new_expiry_us)
            && $stable(o_target_list) && $stable(o_saturated))
        else $error("stalled item changed");

    a_expired_not_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_target_list == LIST_EXPIRED) |-> !o_saturated)
        else $error("expired item flagged saturated");

    a_sat_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (o_new_expiry_us == TIME_MAX))
        else $error("saturated item not at maximum");

endmodule

bind adaptive_flow_expiry_timer_top afet_checker u_afet_checker (.*);

`default_nettype wire

// ----- tb/afet_expiry_checker.sv -----
// Checker for the adaptive flow expiry timer: watches the config, input and output
// channels, predicts each result and compares it field by field. Depends on afet_pkg.
`timescale 1ns / 1ps

module afet_expiry_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_flow_start_us,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_flow_last_us,
    input  wire logic [afet_pkg::COUNT_BITS-1:0]    i_packets_inbound,
    input  wire logic [afet_pkg::COUNT_BITS-1:0]    i_packets_outbound,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_current_expiry_us,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_now_us,
    input  wire logic [afet_pkg::PROTO_BITS-1:0]    i_transport_proto,
    input  wire logic [1:0]                         i_close_state,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic [afet_pkg::TIME_BITS-1:0]     i_new_expiry_us,
    input  wire logic [1:0]                         i_target_list,
    input  wire logic                               i_saturated,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_ready,
    input  wire logic [afet_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [afet_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                      o_errors,
    output int                                      o_pending
);
    import afet_pkg::*;

    logic [1:0]             cfg_mode;
    logic [MULT_BITS-1:0]   cfg_mult;
    logic [PERIOD_BITS-1:0] cfg_min_period;
    logic [PERIOD_BITS-1:0] cfg_short_period;
    logic [PERIOD_BITS-1:0] cfg_short_limit;

    t_result expiry_q[$];
    t_result want;
    int      error_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic t_result predict_expiry(
        input logic [TIME_BITS-1:0]  start_us,
        input logic [TIME_BITS-1:0]  last_us,
        input logic [COUNT_BITS-1:0] pkts_in,
        input logic [COUNT_BITS-1:0] pkts_out,
        input logic [TIME_BITS-1:0]  expiry_us,
        input logic [TIME_BITS-1:0]  now_us,
        input logic [PROTO_BITS-1:0] proto,
        input logic [1:0]            close_state
    );
        logic [TIME_BITS-1:0] span_us;
        logic [COUNT_BITS:0]  pkt_total;
        logic [TIME_BITS-1:0] gap_us;
        logic [PROD_BITS-1:0] prod;
        logic [TIME_BITS-1:0] stream_us;
        logic                 stream_clip;
        logic [TIME_BITS:0]   min_sum;
        logic [TIME_BITS-1:0] min_end_us;
        logic                 min_clip;
        logic [TIME_BITS:0]   fixed_sum;
        logic [TIME_BITS:0]   now_sum;
        t_result              res;

        span_us   = (last_us >= start_us) ? last_us - start_us : '0;
        pkt_total = {1'b0, pkts_in} + {1'b0, pkts_out};
        gap_us    = (pkt_total != '0) ? TIME_BITS'(span_us / pkt_total) : '0;

        prod        = PROD_BITS'(gap_us) * PROD_BITS'(cfg_mult);
        stream_clip = (prod > PROD_BITS'(TIME_MAX));
        stream_us   = stream_clip ? TIME_MAX : prod[TIME_BITS-1:0];

        min_sum    = {1'b0, start_us} + (TIME_BITS+1)'(cfg_min_period);
        min_clip   = min_sum[TIME_BITS];
        min_end_us = min_clip ? TIME_MAX : min_sum[TIME_BITS-1:0];

        now_sum = {1'b0, stream_us} + {1'b0, now_us};

        res.expiry_us = expiry_us;
        res.sat       = 1'b0;

        if (cfg_mode == MODE_STD) begin
            if (expiry_us == '0) begin
                res.expiry_us = min_end_us;
                res.sat       = min_clip;
            end else if (now_us >= min_end_us) begin
                res.expiry_us = now_sum[TIME_BITS] ? TIME_MAX : now_sum[TIME_BITS-1:0];
                res.sat       = now_sum[TIME_BITS] | stream_clip;
            end
        end else if (cfg_mode == MODE_SHORT) begin
            if (pkt_total < (COUNT_BITS+1)'(cfg_short_limit)) begin
                fixed_sum     = {1'b0, start_us} + (TIME_BITS+1)'(cfg_short_period);
                res.expiry_us = fixed_sum[TIME_BITS] ? TIME_MAX : fixed_sum[TIME_BITS-1:0];
                res.sat       = fixed_sum[TIME_BITS];
            end else if (now_us >= min_end_us) begin
                res.expiry_us = now_sum[TIME_BITS] ? TIME_MAX : now_sum[TIME_BITS-1:0];
                res.sat       = now_sum[TIME_BITS] | stream_clip;
            end
        end

        res.list = (proto == PROTO_TCP) ? LIST_TCP : LIST_UDP;

        if (t_close'(close_state) != CLOSE_OPEN) begin
            res.expiry_us = now_us;
            res.sat       = 1'b0;
            res.list      = LIST_EXPIRED;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mode         = MODE_STD;
            cfg_mult         = MULT_RESET;
            cfg_min_period   = MIN_RESET;
            cfg_short_period = SHORT_RESET;
            cfg_short_limit  = LIMIT_RESET;
            expiry_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MODE:  cfg_mode         = i_cfg_data[1:0];
                    CFG_MULT:  cfg_mult         = i_cfg_data[MULT_BITS-1:0];
                    CFG_MIN:   cfg_min_period   = i_cfg_data[PERIOD_BITS-1:0];
                    CFG_SHORT: cfg_short_period = i_cfg_data[PERIOD_BITS-1:0];
                    CFG_LIMIT: cfg_short_limit  = i_cfg_data[PERIOD_BITS-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expiry_q.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no item pending: expected none, actual %0h/%0d/%0d",
                             $time, i_new_expiry_us, i_target_list, i_saturated);
                end else begin
                    want = expiry_q.pop_front();
                    if (i_new_expiry_us !== want.expiry_us || i_target_list !== want.list ||
                        i_saturated !== want.sat) begin
                        error_count++;
                        $display("%0t: expiry/list/sat expected %0h/%0d/%0d, actual %0h/%0d/%0d",
                                 $time, want.expiry_us, want.list, want.sat,
                                 i_new_expiry_us, i_target_list, i_saturated);
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                expiry_q.push_back(predict_expiry(i_flow_start_us, i_flow_last_us,
                                                  i_packets_inbound, i_packets_outbound,
                                                  i_current_expiry_us, i_now_us,
                                                  i_transport_proto, i_close_state));
            end
        end
        o_errors  <= error_count;
        o_pending <= expiry_q.size();
    end

endmodule

// ----- tb/tb_adaptive_flow_expiry_timer_top.sv -----
// Testbench top for the adaptive flow expiry timer: clock, reset, config phases,
// directed and random flow items, random idling; verdict from afet_expiry_checker.
`timescale 1ns / 1ps

module tb_adaptive_flow_expiry_timer_top;
    import afet_pkg::*;

    localparam logic [PROTO_BITS-1:0]   PROTO_UDP   = PROTO_BITS'(17);
    localparam logic [1:0]              MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED  = CFG_IDX_BITS'(7);
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [PERIOD_BITS-1:0]  PERIOD_MAX  = {PERIOD_BITS{1'b1}};

    typedef struct packed {
        logic [TIME_BITS-1:0]  start_us;
        logic [TIME_BITS-1:0]  last_us;
        logic [COUNT_BITS-1:0] pkts_in;
        logic [COUNT_BITS-1:0] pkts_out;
        logic [TIME_BITS-1:0]  expiry_us;
        logic [TIME_BITS-1:0]  now_us;
        logic [PROTO_BITS-1:0] proto;
        t_close                close;
    } t_flow;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [TIME_BITS-1:0]     i_flow_start_us;
    logic [TIME_BITS-1:0]     i_flow_last_us;
    logic [COUNT_BITS-1:0]    i_packets_inbound;
    logic [COUNT_BITS-1:0]    i_packets_outbound;
    logic [TIME_BITS-1:0]     i_current_expiry_us;
    logic [TIME_BITS-1:0]     i_now_us;
    logic [PROTO_BITS-1:0]    i_transport_proto;
    logic [1:0]               i_close_state;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [TIME_BITS-1:0]     o_new_expiry_us;
    logic [1:0]               o_target_list;
    logic                     o_saturated;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    int                     fail_count;
    int                     pending;
    int                     idle_pct = 25;
    logic [PERIOD_BITS-1:0] cur_min_period = MIN_RESET;

    adaptive_flow_expiry_timer_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_flow_start_us     (i_flow_start_us),
        .i_flow_last_us      (i_flow_last_us),
        .i_packets_inbound   (i_packets_inbound),
        .i_packets_outbound  (i_packets_outbound),
        .i_current_expiry_us (i_current_expiry_us),
        .i_now_us            (i_now_us),
        .i_transport_proto   (i_transport_proto),
        .i_close_state       (i_close_state),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_new_expiry_us     (o_new_expiry_us),
        .o_target_list       (o_target_list),
        .o_saturated         (o_saturated),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    afet_expiry_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_flow_start_us     (i_flow_start_us),
        .i_flow_last_us      (i_flow_last_us),
        .i_packets_inbound   (i_packets_inbound),
        .i_packets_outbound  (i_packets_outbound),
        .i_current_expiry_us (i_current_expiry_us),
        .i_now_us            (i_now_us),
        .i_transport_proto   (i_transport_proto),
        .i_close_state       (i_close_state),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_new_expiry_us     (o_new_expiry_us),
        .i_target_list       (o_target_list),
        .i_saturated         (o_saturated),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_errors            (fail_count),
        .o_pending           (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_span();
        int unsigned w;
        logic [TIME_BITS-1:0] v;
        w = $urandom_range(0, TIME_BITS);
        v = rand_time();
        return (w == 0) ? '0 : v >> (TIME_BITS - w);
    endfunction

    function automatic logic [TIME_BITS-1:0] clamp_add(input logic [TIME_BITS-1:0] a,
                                                       input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic t_flow flow(input logic [TIME_BITS-1:0] start_us, last_us,
                                   input logic [COUNT_BITS-1:0] pkts_in, pkts_out,
                                   input logic [TIME_BITS-1:0] expiry_us, now_us,
                                   input logic [PROTO_BITS-1:0] proto,
                                   input t_close close);
        t_flow f;
        f.start_us  = start_us;
        f.last_us   = last_us;
        f.pkts_in   = pkts_in;
        f.pkts_out  = pkts_out;
        f.expiry_us = expiry_us;
        f.now_us    = now_us;
        f.proto     = proto;
        f.close     = close;
        return f;
    endfunction

    function automatic t_flow make_flow(input logic [PERIOD_BITS-1:0] min_period);
        t_flow f;
        int unsigned pick;
        logic [TIME_BITS-1:0] len;
        logic [TIME_BITS-1:0] min_end;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // noise: every field uniform over its full width
            return flow(rand_time(), rand_time(), $urandom, $urandom, rand_time(), rand_time(),
                        PROTO_BITS'($urandom), t_close'(2'($urandom)));
        end
        f.start_us = ($urandom_range(0, 7) == 0) ? TIME_MAX - rand_span() : rand_span();
        len = rand_span();
        if (pick == 1)
            f.last_us = (f.start_us >= len) ? f.start_us - len : '0;
        else
            f.last_us = clamp_add(f.start_us, len);
        min_end = clamp_add(f.start_us, TIME_BITS'(min_period));
        case ($urandom_range(0, 2))
            0: f.now_us = clamp_add(f.last_us, rand_span());
            1: f.now_us = min_end - TIME_BITS'($urandom_range(0, 2));
            default: f.now_us = clamp_add(min_end, TIME_BITS'($urandom_range(0, 2)));
        endcase
        case ($urandom_range(0, 3))
            0: begin
                f.pkts_in  = $urandom_range(0, 8);
                f.pkts_out = $urandom_range(0, 8);
            end
            1: begin
                f.pkts_in  = '0;
                f.pkts_out = $urandom_range(0, 12);
            end
            2: begin
                f.pkts_in  = $urandom_range(0, 1000);
                f.pkts_out = $urandom_range(0, 1000);
            end
            default: begin
                f.pkts_in  = $urandom;
                f.pkts_out = $urandom;
            end
        endcase
        case ($urandom_range(0, 2))
            0: f.expiry_us = '0;
            1: f.expiry_us = clamp_add(f.now_us, rand_span());
            default: f.expiry_us = rand_time();
        endcase
        f.proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_BITS'($urandom);
        f.close = ($urandom_range(0, 3) != 0) ? CLOSE_OPEN : t_close'($urandom_range(1, 3));
        return f;
    endfunction

    task automatic send_flow(input t_flow f);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_flow_start_us     <= f.start_us;
        i_flow_last_us      <= f.last_us;
        i_packets_inbound   <= f.pkts_in;
        i_packets_outbound  <= f.pkts_out;
        i_current_expiry_us <= f.expiry_us;
        i_now_us            <= f.now_us;
        i_transport_proto   <= f.proto;
        i_close_state       <= f.close;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic [MULT_BITS-1:0] mult,
                                  input logic [PERIOD_BITS-1:0] min_period,
                                  input logic [PERIOD_BITS-1:0] short_period,
                                  input logic [PERIOD_BITS-1:0] short_limit);
        // unused index and stray upper bits must not disturb any register
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_MODE, {30'($urandom), mode});
        write_reg(CFG_MULT, {24'($urandom), mult});
        write_reg(CFG_MIN, min_period);
        write_reg(CFG_SHORT, short_period);
        write_reg(CFG_LIMIT, short_limit);
        i_cfg_valid    <= 1'b0;
        cur_min_period = min_period;
    endtask

    task automatic run_random(input int n, input int pct);
        idle_pct = pct;
        repeat (n) send_flow(make_flow(cur_min_period));
        drain();
    endtask

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_flow_start_us     <= '0;
        i_flow_last_us      <= '0;
        i_packets_inbound   <= '0;
        i_packets_outbound  <= '0;
        i_current_expiry_us <= '0;
        i_now_us            <= '0;
        i_transport_proto   <= '0;
        i_close_state       <= '0;
        i_cfg_valid         <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_data          <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items under reset settings
        send_flow(flow('0, '0, '0, '0, '0, '0, '0, CLOSE_OPEN));
        send_flow(flow(TIME_MAX, TIME_MAX, COUNT_MAX, COUNT_MAX, TIME_MAX, TIME_MAX,
                       '1, CLOSE_CLOSED));
        send_flow(flow(TIME_MAX - 10, TIME_MAX - 5, 3, 4, '0, TIME_MAX, PROTO_TCP, CLOSE_OPEN));
        send_flow(flow(1000, 2000, 5, 5, 7000000, 3000000, PROTO_TCP, CLOSE_OPEN));
        send_flow(flow(1000, 1000000, 10, 10, 7000000, 6000000, PROTO_UDP, CLOSE_OPEN));
        send_flow(flow(1000, 900000, 0, 0, 123, 6000000, PROTO_UDP, CLOSE_OPEN));
        send_flow(flow(500000, 1000, 2, 2, 123, 6000000, PROTO_TCP, CLOSE_OPEN));
        send_flow(flow('0, TIME_MAX, COUNT_MAX, COUNT_MAX, 1, 6000000, PROTO_UDP, CLOSE_OPEN));
        send_flow(flow('0, TIME_MAX, 0, 1, 1, 6000000, PROTO_TCP, CLOSE_OPEN));
        send_flow(flow('0, 100000, 1, 1, 1, TIME_MAX - 3, PROTO_UDP, CLOSE_OPEN));
        send_flow(flow('0, 4000000, 4, 4, 1, 5000000, PROTO_TCP, CLOSE_OPEN));
        send_flow(flow('0, 4000000, 4, 4, 1, 4999999, PROTO_TCP, CLOSE_OPEN));
        send_flow(flow(1000, 2000000, 3, 3, 9000, 8000000, PROTO_TCP, CLOSE_RESET));
        send_flow(flow(1000, 2000000, 3, 3, 0, 8000000, PROTO_UDP, CLOSE_ICMP));
        send_flow(flow(1000, 2000000, 3, 3, 9000, 8000000, PROTO_UDP, CLOSE_CLOSED));
        send_flow(flow(1000, 2000000, 3, 3, 9000, 8000000, PROTO_BITS'(PROTO_TCP + 1),
                       CLOSE_OPEN));
        send_flow(flow(1000, 2000000, 3, 3, 9000, 8000000, PROTO_BITS'(PROTO_TCP - 1),
                       CLOSE_OPEN));
        send_flow(flow(48'hAAAA_AAAA_AAAA, 48'hD555_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                       48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 8'h55, CLOSE_OPEN));
        run_random(80, 25);

        apply_settings(MODE_SHORT, MULT_RESET, MIN_RESET, SHORT_RESET, LIMIT_RESET);
        run_random(80, 40);

        apply_settings(MODE_KEEP, MULT_BITS'(1), 1000, 500, 100);
        run_random(60, 0);

        apply_settings(MODE_UNUSED, MULT_BITS'(255), $urandom, $urandom, $urandom);
        run_random(40, 30);

        apply_settings(MODE_STD, MULT_BITS'(255), '0, '0, '0);
        run_random(60, 20);

        apply_settings(MODE_SHORT, MULT_BITS'(1), PERIOD_MAX, PERIOD_MAX, PERIOD_MAX);
        run_random(60, 50);

        apply_settings(MODE_STD, '0, $urandom_range(0, 100000), $urandom, $urandom_range(0, 20));
        run_random(40, 25);

        apply_settings(MODE_SHORT, '0, '0, PERIOD_MAX, $urandom_range(0, 20));
        run_random(50, 30);

        apply_settings(MODE_STD, MULT_BITS'($urandom_range(1, 255)), MIN_RESET, SHORT_RESET,
                       $urandom_range(0, 40));
        run_random(80, 0);

        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/afet_pkg.sv
sv/afet_div_cell.sv
sv/afet_out_fifo.sv
sv/adaptive_flow_expiry_timer_top.sv
sv/afet_checker.sv
tb/afet_expiry_checker.sv
tb/tb_adaptive_flow_expiry_timer_top.sv
